### src/ifcl_pkg.sv
// ----------------------------------------------------------------------------
// ifcl_pkg
// Shared types, constants and helpers for the IPv4 forwarding check with
// longest-prefix route lookup.
// ----------------------------------------------------------------------------
package ifcl_pkg;

	// Route table geometry
	localparam int ROUTE_ENTRIES = 16;
	localparam int RIDX_W        = 4;
	localparam int RCNT_W        = 5;

	// Header geometry
	localparam int HDR_BYTES = 20;
	localparam int HDR_WORDS = HDR_BYTES / 4;
	localparam int WCNT_W    = 3;

	localparam logic [WCNT_W-1:0] WORD_LEN  = WCNT_W'(0);
	localparam logic [WCNT_W-1:0] WORD_TTL  = WCNT_W'(2);
	localparam logic [WCNT_W-1:0] WORD_SRC  = WCNT_W'(3);
	localparam logic [WCNT_W-1:0] WORD_LAST = WCNT_W'(HDR_WORDS - 1);

	localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

	// Item kinds
	localparam logic FUNC_ROUTE = 1'b0;
	localparam logic FUNC_HDR   = 1'b1;

	// Configuration registers
	localparam int  APB_AW          = 3;
	localparam logic REG_ROUTE_COUNT = 1'b0;

	// Result status codes
	typedef enum logic [1:0] {
		ST_FWD     = 2'd0,
		ST_TTL     = 2'd1,
		ST_CSUM    = 2'd2,
		ST_NOROUTE = 2'd3
	} status_t;

	// Search token handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic [31:0] dest;
		logic        found;
		logic [31:0] mask;
		logic [31:0] hop;
	} token_t;

	// Header state seen by the top level
	typedef struct packed {
		logic        last;
		logic        csum_ok;
		logic [7:0]  new_ttl;
		logic [31:0] source;
		logic [15:0] length;
	} hdr_info_t;

	// Ones'-complement add with end-around carry
	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'b0, s[16]};
	endfunction

endpackage

### src/ifcl_hdr.sv
// ----------------------------------------------------------------------------
// ifcl_hdr
// Header word counter, running ones'-complement checksum and held fields.
// ----------------------------------------------------------------------------
module ifcl_hdr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_en,
	input  logic [31:0]         word,
	output ifcl_pkg::hdr_info_t info
);
	import ifcl_pkg::*;

	logic [WCNT_W-1:0] cnt_q;
	logic [15:0]       sum_q;
	logic [15:0]       sum_next;
	logic              csum_ok_q;
	logic [7:0]        ttl_q;
	logic [31:0]       source_q;
	logic [15:0]       length_q;
	logic              last;

	// Fold both halfwords into the running sum
	assign sum_next = ones_add(ones_add(sum_q, word[31:16]), word[15:0]);
	assign last     = (cnt_q == WORD_LAST);

	// Advance count and sum; clear both after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (word_en) begin
			if (last) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_q + WCNT_W'(1);
				sum_q <= sum_next;
			end
		end
	end

	// Capture header fields and the checksum verdict
	always_ff @(posedge clk) begin
		if (word_en) begin
			case (cnt_q)
				WORD_LEN: length_q <= word[15:0];
				WORD_TTL: ttl_q    <= word[31:24];
				WORD_SRC: source_q <= word;
				default:  ;
			endcase
			if (last) begin
				csum_ok_q <= (sum_next == CSUM_GOOD);
			end
		end
	end

	assign info.last    = last;
	assign info.csum_ok = csum_ok_q;
	assign info.new_ttl = ttl_q - 8'd1;
	assign info.source  = source_q;
	assign info.length  = length_q;

endmodule

### src/ifcl_cell.sv
// ----------------------------------------------------------------------------
// ifcl_cell
// One route table entry and one stage of the lookup chain.
// ----------------------------------------------------------------------------
module ifcl_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [31:0]      wr_prefix,
	input  logic [31:0]      wr_mask,
	input  logic [31:0]      wr_hop,
	input  logic             active,
	input  ifcl_pkg::token_t tok_in,
	output ifcl_pkg::token_t tok_out
);
	import ifcl_pkg::*;

	logic [31:0] prefix_q;
	logic [31:0] mask_q;
	logic [31:0] hop_q;
	logic        valid_q;
	logic [31:0] dest_q;
	logic        found_q;
	logic [31:0] best_mask_q;
	logic [31:0] best_hop_q;
	logic        hit;
	logic        take;

	// Store the entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prefix_q <= wr_prefix;
			mask_q   <= wr_mask;
			hop_q    <= wr_hop;
		end
	end

	// Match, and prefer a longer or equal mask so the later entry wins ties
	always_comb begin
		hit  = tok_in.valid && active && ((tok_in.dest & mask_q) == prefix_q);
		take = hit && (!tok_in.found || (mask_q >= tok_in.mask));
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		dest_q      <= tok_in.dest;
		found_q     <= tok_in.found | hit;
		best_mask_q <= take ? mask_q : tok_in.mask;
		best_hop_q  <= take ? hop_q : tok_in.hop;
	end

	assign tok_out.valid = valid_q;
	assign tok_out.dest  = dest_q;
	assign tok_out.found = found_q;
	assign tok_out.mask  = best_mask_q;
	assign tok_out.hop   = best_hop_q;

endmodule

### src/ipv4_forward_check_lpm.sv
// ----------------------------------------------------------------------------
// ipv4_forward_check_lpm
// IPv4 header check and longest-prefix route lookup over a chain of cells.
// ----------------------------------------------------------------------------
// Header words and route items transfer at one per cycle while no lookup runs
// and, for the last header word, no result waits. Accepting the fifth header
// word launches a token down 16 route cells, one cell per cycle; the result
// is registered after the last cell, and input stalls until the token leaves it.
// Reset clears the word count, checksum, route_count and the valid flags;
// table entries are undefined until written.
module ipv4_forward_check_lpm (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input channel
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        func,
	input  logic [ifcl_pkg::RIDX_W-1:0] route_index,
	input  logic [31:0]                 route_prefix,
	input  logic [31:0]                 route_mask,
	input  logic [31:0]                 route_next_hop,
	input  logic [31:0]                 header_word,
	// Result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [1:0]                  status,
	output logic [7:0]                  new_ttl,
	output logic [31:0]                 source_addr,
	output logic [31:0]                 dest_addr,
	output logic [15:0]                 total_length,
	output logic [31:0]                 next_hop,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ifcl_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import ifcl_pkg::*;

	logic                    item_xfer;
	logic                    hdr_en;
	logic                    route_wr;
	logic                    launch;
	logic                    busy_q;
	logic [RCNT_W-1:0]       route_count_q;
	hdr_info_t               hinfo;
	token_t                  tok [ROUTE_ENTRIES+1];
	token_t                  tok_end;
	status_t                 st;
	logic                    res_valid_q;
	status_t                 res_status_q;
	logic [7:0]              res_ttl_q;
	logic [31:0]             res_source_q;
	logic [31:0]             res_dest_q;
	logic [15:0]             res_length_q;
	logic [31:0]             res_hop_q;

	// Input handshake: hold off during a lookup, and hold the last word while
	// a result still waits
	assign item_stall = busy_q || (res_valid_q && hinfo.last);
	assign item_xfer  = item_valid && !item_stall;
	assign hdr_en     = item_xfer && (func == FUNC_HDR);
	assign route_wr   = item_xfer && (func == FUNC_ROUTE);
	assign launch     = hdr_en && hinfo.last;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ROUTE_COUNT)) begin
			route_count_q <= pwdata[RCNT_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_ROUTE_COUNT) ? 32'(route_count_q) : '0;

	// Header accumulation
	ifcl_hdr u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.word_en(hdr_en),
		.word   (header_word),
		.info   (hinfo)
	);

	// Launch token
	assign tok[0].valid = launch;
	assign tok[0].dest  = header_word;
	assign tok[0].found = 1'b0;
	assign tok[0].mask  = '0;
	assign tok[0].hop   = '0;

	// Route cell chain
	for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
		logic wr_en;
		logic active;
		assign wr_en  = route_wr && (int'(route_index) == i);
		assign active = (int'(route_count_q) > i);
		ifcl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_prefix(route_prefix),
			.wr_mask  (route_mask),
			.wr_hop   (route_next_hop),
			.active   (active),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end
	assign tok_end = tok[ROUTE_ENTRIES];

	// Track the lookup in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (launch) begin
			busy_q <= 1'b1;
		end else if (tok_end.valid) begin
			busy_q <= 1'b0;
		end
	end

	// Verdict, checksum first
	always_comb begin
		if (!hinfo.csum_ok) begin
			st = ST_CSUM;
		end else if (hinfo.new_ttl == 8'd0) begin
			st = ST_TTL;
		end else if (!tok_end.found) begin
			st = ST_NOROUTE;
		end else begin
			st = ST_FWD;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tok_end.valid) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			res_status_q <= st;
			res_ttl_q    <= hinfo.new_ttl;
			res_source_q <= hinfo.source;
			res_dest_q   <= tok_end.dest;
			res_length_q <= hinfo.length;
			res_hop_q    <= (st == ST_FWD) ? tok_end.hop : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign new_ttl      = res_ttl_q;
	assign source_addr  = res_source_q;
	assign dest_addr    = res_dest_q;
	assign total_length = res_length_q;
	assign next_hop     = res_hop_q;

endmodule

### src/ifcl_chk.sv
// ----------------------------------------------------------------------------
// ifcl_chk
// Port-level checks for the forwarding check block, bound to its top level.
// ----------------------------------------------------------------------------
module ifcl_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [1:0]                  status,
	input logic [7:0]                  new_ttl,
	input logic [31:0]                 source_addr,
	input logic [31:0]                 dest_addr,
	input logic [15:0]                 total_length,
	input logic [31:0]                 next_hop
);
	import ifcl_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(next_hop) && $stable(dest_addr) && $stable(new_ttl)
			&& $stable(source_addr) && $stable(total_length))
		else $error("stalled result changed");

	// Only a forwarded packet carries a next hop
	a_hop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_FWD) |-> next_hop == 32'd0)
		else $error("next hop set on a dropped packet");

	// A forwarded packet has a live TTL
	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_FWD) |-> new_ttl != 8'd0)
		else $error("forwarded with expired TTL");

	// A new result comes only out of a lookup, during which input is held off
	a_res_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a lookup");

endmodule

bind ipv4_forward_check_lpm ifcl_chk u_ifcl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_stall  (item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.status      (status),
	.new_ttl     (new_ttl),
	.source_addr (source_addr),
	.dest_addr   (dest_addr),
	.total_length(total_length),
	.next_hop    (next_hop)
);
